FILE: rtl/collection_mode_controller_assert.svh
// assertion macros for the collection mode controller
// no dependencies; included by files that carry concurrent checks
`ifndef COLLECTION_MODE_CONTROLLER_ASSERT_SVH
`define COLLECTION_MODE_CONTROLLER_ASSERT_SVH

`ifndef SYNTH

// check under reset: disabled while arst_n is low
`define CMC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, including during reset
`define CMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CMC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/cmc_pkg.sv
// shared types, constants and helpers of the collection mode controller
// no dependencies
`default_nettype none

package cmc_pkg;

	// item kinds
	localparam logic [1:0] FUNC_CMD    = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_SAMPLE = 2'd2;

	// command characters
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_STOP  = 8'h53;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// frame characters
	localparam logic [7:0] FRAME_HEAD  = 8'd65;
	localparam logic [7:0] FRAME_TAIL  = 8'd90;
	localparam logic [7:0] FLAG_LIT    = 8'd97;
	localparam logic [7:0] FLAG_DARK   = 8'd89;
	localparam logic [7:0] SUN_SET_CH  = 8'd115;
	localparam logic [7:0] SUN_RISE_CH = 8'd114;
	localparam logic [7:0] SUN_NONE_CH = 8'd0;

	localparam logic [15:0] BELOW_LIMIT   = 16'd100;
	localparam logic [15:0] THRESH_RESET  = 16'd330;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
	localparam logic [4:0]  FRAME_LAST    = 5'd19;

	// command buffer geometry
	localparam logic [2:0] IDX_THIRD = 3'd2;
	localparam logic [2:0] IDX_SIXTH = 3'd5;

	// mode bits
	localparam int MODE3_BIT = 2;
	localparam int MODE4_BIT = 3;

	// one captured frame, ready to serialize
	typedef struct packed {
		logic [31:0] time_ms;
		logic [15:0] photodiode_level;
		logic [7:0]  thresh_ch;
		logic [7:0]  sun_ch;
		logic [15:0] optics_temp;
		logic [15:0] analog_board_temp;
		logic [15:0] digital_board_temp;
		logic [15:0] analog_supply_current;
		logic [15:0] digital_supply_current;
		logic        collecting;
		logic [3:0]  active_modes;
	} frame_t;

	// ascii decimal digit test
	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// leading decimal value of up to three digit characters
	function automatic logic [9:0] digits_value(input logic [7:0] c0,
		input logic [7:0] c1, input logic [7:0] c2);
		logic [9:0] d0;
		logic [9:0] d1;
		logic [9:0] d2;
		logic [9:0] v;
		d0 = {6'd0, c0[3:0]};
		d1 = {6'd0, c1[3:0]};
		d2 = {6'd0, c2[3:0]};
		if (!is_digit(c0))
			v = 10'd0;
		else if (!is_digit(c1))
			v = d0;
		else if (!is_digit(c2))
			v = 10'(d0 * 10'd10) + d1;
		else
			v = 10'(d0 * 10'd100) + 10'(d1 * 10'd10) + d2;
		return v;
	endfunction

	// byte k of the telemetry frame
	function automatic logic [7:0] frame_byte_at(input frame_t f, input logic [4:0] k);
		logic [7:0] b;
		case (k)
			5'd0:    b = FRAME_HEAD;
			5'd1:    b = f.time_ms[7:0];
			5'd2:    b = f.time_ms[15:8];
			5'd3:    b = f.time_ms[23:16];
			5'd4:    b = f.time_ms[31:24];
			5'd5:    b = f.photodiode_level[7:0];
			5'd6:    b = f.photodiode_level[15:8];
			5'd7:    b = f.thresh_ch;
			5'd8:    b = f.sun_ch;
			5'd9:    b = f.optics_temp[7:0];
			5'd10:   b = f.optics_temp[15:8];
			5'd11:   b = f.analog_board_temp[7:0];
			5'd12:   b = f.analog_board_temp[15:8];
			5'd13:   b = f.digital_board_temp[7:0];
			5'd14:   b = f.digital_board_temp[15:8];
			5'd15:   b = f.analog_supply_current[7:0];
			5'd16:   b = f.analog_supply_current[15:8];
			5'd17:   b = f.digital_supply_current[7:0];
			5'd18:   b = f.digital_supply_current[15:8];
			default: b = FRAME_TAIL;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cmc_if.sv
// valid/ready channel interfaces of the collection mode controller
// no dependencies
`default_nettype none

// input item channel
interface cmc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  command_char;
	logic [15:0] photodiode_level;
	logic [31:0] time_ms;
	logic [15:0] optics_temp;
	logic [15:0] analog_board_temp;
	logic [15:0] digital_board_temp;
	logic [15:0] analog_supply_current;
	logic [15:0] digital_supply_current;

	modport source (output valid, func, command_char, photodiode_level, time_ms,
		optics_temp, analog_board_temp, digital_board_temp,
		analog_supply_current, digital_supply_current, input ready);
	modport sink (input valid, func, command_char, photodiode_level, time_ms,
		optics_temp, analog_board_temp, digital_board_temp,
		analog_supply_current, digital_supply_current, output ready);
endinterface

// frame byte channel
interface cmc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_of_frame;
	logic       collecting;
	logic [3:0] active_modes;

	modport source (output valid, frame_byte, last_of_frame, collecting, active_modes,
		input ready);
	modport sink (input valid, frame_byte, last_of_frame, collecting, active_modes,
		output ready);
endinterface

// threshold register write channel
interface cmc_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] dark_threshold;

	modport source (output valid, dark_threshold, input ready);
	modport sink (input valid, dark_threshold, output ready);
endinterface

`default_nettype wire

FILE: rtl/collection_mode_controller.sv
// collection mode controller top level: command decode, mode state, frame serializer
// depends on cmc_pkg, cmc_if and collection_mode_controller_assert.svh
//
// channel | modport | beat
// --------+---------+------------------------------------------------------
// item    | sink    | command byte, one-second tick or sample set
// result  | source  | one telemetry frame byte with last/collecting/modes
// cfg     | sink    | dark_threshold write, always ready
//
// command bytes and ticks update state on acceptance
// a sample set is captured on acceptance and moves to the serializer once it is free;
// its 20 bytes follow one per cycle while result.ready is high; the byte serializer
// sets the sustained sample rate, and one frame can wait while the previous one
// is sent; while a frame waits and the serializer is busy, every item kind is held
// off until the last byte is taken
// reset clears mode state and counters and sets the threshold to 330; the command
// buffer is not reset; a stalled result holds until taken
`default_nettype none

`include "collection_mode_controller_assert.svh"

module collection_mode_controller (
	input  wire logic clk,
	input  wire logic arst_n,
	cmc_in_if.sink    item,
	cmc_out_if.source result,
	cmc_cfg_if.sink   cfg
);
	import cmc_pkg::*;

	// state
	logic [15:0] thresh_q;
	logic        collect_q;
	logic [3:0]  mode_q;
	logic [15:0] elapsed_q;
	logic [9:0]  limit_q;
	logic [15:0] below_q;
	logic [1:0]  sun_q;
	logic [2:0]  cmd_idx_q;
	logic [7:0]  cmd_buf_q [6];

	// captured frame and serializer
	logic        frame_vld_s1;
	frame_t      frame_s1;
	frame_t      frame_q;
	logic        busy_q;
	logic [4:0]  byte_idx_q;

	logic        item_fire;
	logic        out_fire;
	logic        last_byte;
	logic        load_ser;

	// next state
	logic        chk_collect;
	logic [3:0]  chk_mode;
	logic [9:0]  chk_limit;
	logic        nxt_collect;
	logic [3:0]  nxt_mode;
	logic [15:0] nxt_elapsed;
	logic [9:0]  nxt_limit;
	logic [15:0] nxt_below;
	logic [1:0]  nxt_sun;
	logic [2:0]  nxt_idx;
	logic        buf_wr;
	logic        full3;
	logic        full6;
	logic        lit;
	frame_t      new_frame;

	// handshakes
	assign out_fire  = busy_q && result.ready;
	assign last_byte = (byte_idx_q == FRAME_LAST);
	assign load_ser  = frame_vld_s1 && (!busy_q || (out_fire && last_byte));
	assign item.ready = !frame_vld_s1 || load_ser;
	assign item_fire = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	// stop checks, then the item's own effect
	always_comb begin
		chk_collect = collect_q;
		chk_mode    = mode_q;
		chk_limit   = limit_q;
		if (mode_q[MODE3_BIT] && (below_q >= BELOW_LIMIT)) begin
			chk_collect         = 1'b0;
			chk_mode[MODE3_BIT] = 1'b0;
		end
		if (mode_q[MODE4_BIT] && (elapsed_q >= {6'd0, limit_q})) begin
			chk_collect         = 1'b0;
			chk_mode[MODE4_BIT] = 1'b0;
			chk_limit           = 10'd0;
		end

		nxt_collect = chk_collect;
		nxt_mode    = chk_mode;
		nxt_limit   = chk_limit;
		nxt_elapsed = elapsed_q;
		nxt_below   = below_q;
		nxt_sun     = sun_q;
		nxt_idx     = cmd_idx_q;
		buf_wr      = 1'b0;
		full3       = (cmd_idx_q == IDX_THIRD) && (item.command_char != CH_FOUR);
		full6       = (cmd_idx_q == IDX_SIXTH);
		lit         = (item.photodiode_level >= thresh_q);

		unique case (item.func)
			FUNC_CMD: begin
				buf_wr  = 1'b1;
				nxt_idx = (full3 || full6) ? 3'd0 : cmd_idx_q + 3'd1;
				if (full6) begin
					// timed mode with decimal limit
					nxt_limit   = digits_value(cmd_buf_q[3], cmd_buf_q[4],
						item.command_char);
					nxt_elapsed = 16'd0;
					nxt_collect = 1'b1;
					nxt_mode[MODE4_BIT] = 1'b1;
				end else if (full3) begin
					if (cmd_buf_q[1] == CH_STOP) begin
						nxt_collect = 1'b0;
						nxt_mode    = chk_mode & 4'b0100;
						nxt_sun     = {sun_q[0], sun_q[1]};
					end else if (cmd_buf_q[0] == CH_AT) begin
						case (item.command_char)
							CH_ONE: begin
								nxt_elapsed = 16'd0;
								nxt_collect = 1'b1;
								nxt_mode[0] = 1'b1;
							end
							CH_TWO: begin
								nxt_elapsed = 16'd0;
								nxt_collect = 1'b1;
								nxt_mode[1] = 1'b1;
							end
							CH_THREE: begin
								nxt_elapsed = 16'd0;
								nxt_collect = 1'b1;
								nxt_mode[MODE3_BIT] = 1'b1;
							end
							default: ;
						endcase
					end
				end
			end
			FUNC_TICK: begin
				if (elapsed_q != COUNT_MAX)
					nxt_elapsed = elapsed_q + 16'd1;
			end
			FUNC_SAMPLE: begin
				if (lit)
					nxt_below = 16'd0;
				else if (below_q != COUNT_MAX)
					nxt_below = below_q + 16'd1;
			end
			default: ;
		endcase
	end

	// frame content of a sample beat
	always_comb begin
		new_frame.time_ms                = item.time_ms;
		new_frame.photodiode_level       = item.photodiode_level;
		new_frame.thresh_ch              = lit ? FLAG_LIT : FLAG_DARK;
		new_frame.sun_ch                 = sun_q[0] ? SUN_SET_CH :
			(sun_q[1] ? SUN_RISE_CH : SUN_NONE_CH);
		new_frame.optics_temp            = item.optics_temp;
		new_frame.analog_board_temp      = item.analog_board_temp;
		new_frame.digital_board_temp     = item.digital_board_temp;
		new_frame.analog_supply_current  = item.analog_supply_current;
		new_frame.digital_supply_current = item.digital_supply_current;
		new_frame.collecting             = chk_collect;
		new_frame.active_modes           = chk_mode;
	end

	// mode and counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= THRESH_RESET;
			collect_q <= 1'b0;
			mode_q    <= 4'd0;
			elapsed_q <= 16'd0;
			limit_q   <= 10'd0;
			below_q   <= 16'd0;
			sun_q     <= 2'd0;
			cmd_idx_q <= 3'd0;
		end else begin
			if (cfg.valid)
				thresh_q <= cfg.dark_threshold;
			if (item_fire) begin
				collect_q <= nxt_collect;
				mode_q    <= nxt_mode;
				elapsed_q <= nxt_elapsed;
				limit_q   <= nxt_limit;
				below_q   <= nxt_below;
				sun_q     <= nxt_sun;
				cmd_idx_q <= nxt_idx;
			end
		end
	end

	// command buffer, written without reset
	always_ff @(posedge clk) begin
		if (item_fire && buf_wr)
			cmd_buf_q[cmd_idx_q] <= item.command_char;
	end

	// captured frame waiting for the serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frame_vld_s1 <= 1'b0;
		else if (item_fire && (item.func == FUNC_SAMPLE))
			frame_vld_s1 <= 1'b1;
		else if (load_ser)
			frame_vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (item_fire && (item.func == FUNC_SAMPLE))
			frame_s1 <= new_frame;
		if (load_ser)
			frame_q <= frame_s1;
	end

	// byte serializer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			byte_idx_q <= 5'd0;
		end else if (load_ser) begin
			busy_q     <= 1'b1;
			byte_idx_q <= 5'd0;
		end else if (out_fire) begin
			if (last_byte)
				busy_q <= 1'b0;
			else
				byte_idx_q <= byte_idx_q + 5'd1;
		end
	end

	// result beat
	assign result.valid         = busy_q;
	assign result.frame_byte    = frame_byte_at(frame_q, byte_idx_q);
	assign result.last_of_frame = last_byte;
	assign result.collecting    = frame_q.collecting;
	assign result.active_modes  = frame_q.active_modes;

	// checks
	`CMC_ASSERT(a_tail_on_last, clk, arst_n,
		(result.valid && result.last_of_frame) |-> (result.frame_byte == FRAME_TAIL),
		"last frame byte is not the tail character")
	`CMC_ASSERT(a_pending_holds, clk, arst_n,
		(frame_vld_s1 && !load_ser) |=> frame_vld_s1,
		"waiting frame dropped before the serializer took it")
	`CMC_ASSERT(a_idx_in_frame, clk, arst_n,
		busy_q |-> (byte_idx_q <= FRAME_LAST),
		"byte index ran past the frame")
	`CMC_ASSERT(a_collect_has_mode, clk, arst_n,
		collect_q |-> (mode_q != 4'd0),
		"collecting with no active mode")
	`CMC_ASSERT_ALWAYS(a_cmd_idx_range, clk,
		!arst_n || (cmd_idx_q <= IDX_SIXTH),
		"command index out of range")

endmodule

`default_nettype wire
